// File: rtl/owcrc_pkg.sv
package owcrc_pkg;

	localparam int unsigned ROM_BYTES = 8;
	localparam int unsigned CNT_W     = 4;
	localparam logic [CNT_W-1:0] COUNT_MAX = 4'hF;
	localparam logic [CNT_W-1:0] ROM_COUNT = CNT_W'(ROM_BYTES);
	localparam logic [7:0] CRC_POLY  = 8'h8C;
	localparam logic [7:0] CRC_INIT  = 8'h00;
	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [7:0] BYTE_ONES = 8'hFF;

	typedef struct packed {
		logic [7:0] crc_value;
		logic       rom_valid;
	} result_t;

	// reflected crc-8, lsb first, eight shift steps unrolled into xor logic
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		logic [7:0] b;
		logic       fb;
		c = crc;
		b = data;
		for (int k = 0; k < 8; k++) begin
			fb = c[0] ^ b[0];
			c  = {1'b0, c[7:1]};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
			b  = {1'b0, b[7:1]};
		end
		return c;
	endfunction

endpackage

// File: rtl/owcrc_accum.sv
module owcrc_accum (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	output owcrc_pkg::result_t   result
);
	import owcrc_pkg::*;

	logic [7:0]       crc_q;
	logic             only_zeros_q;
	logic             only_ones_q;
	logic [CNT_W-1:0] count_q;

	logic [7:0]       crc_next;
	logic             only_zeros_next;
	logic             only_ones_next;
	logic [CNT_W-1:0] count_next;

	always_comb begin
		crc_next        = crc8_byte(crc_q, data_byte);
		only_zeros_next = only_zeros_q & (data_byte == BYTE_ZERO);
		only_ones_next  = only_ones_q & (data_byte == BYTE_ONES);
		count_next      = (count_q == COUNT_MAX) ? count_q : count_q + CNT_W'(1);
	end

	always_comb begin
		result.crc_value = crc_next;
		result.rom_valid = (count_next == ROM_COUNT) && !only_zeros_next &&
			!only_ones_next && (crc_next == CRC_INIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q        <= CRC_INIT;
			only_zeros_q <= 1'b1;
			only_ones_q  <= 1'b1;
			count_q      <= '0;
		end else if (step) begin
			if (last_byte) begin
				// message done, start over for the next one
				crc_q        <= CRC_INIT;
				only_zeros_q <= 1'b1;
				only_ones_q  <= 1'b1;
				count_q      <= '0;
			end else begin
				crc_q        <= crc_next;
				only_zeros_q <= only_zeros_next;
				only_ones_q  <= only_ones_next;
				count_q      <= count_next;
			end
		end
	end

endmodule

// File: rtl/onewire_rom_crc_checker.sv
// channel  | dir | tdata          | tlast      | tuser
// s        | in  | [7:0] data_byte| last_byte  | -
// m        | out | [7:0] crc_value| -          | [0] rom_valid
//
// one byte per cycle sustained unless a last byte is held back; a result passes from
// its last byte through the input register, then crc/flag update into the result register
// non-last bytes never wait on the output side; a last byte waits in the
// input register only while the result register is full and m_tready is low
// arst_n resets the running crc, flags and byte count and clears both valid bits
module onewire_rom_crc_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] crc_value
	output logic       m_tuser    // [0] rom_valid
);
	import owcrc_pkg::*;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       out_valid_q;
	result_t    out_q;
	result_t    result;
	logic       out_free;
	logic       advance;

	assign out_free = !out_valid_q || m_tready;
	// a non-last byte only updates state, so it never needs the output slot
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	owcrc_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && last_s1) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.crc_value;
	assign m_tuser  = out_q.rom_valid;

endmodule

// File: rtl/owcrc_checker.sv
module owcrc_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       s_tlast,
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,
	input  logic       m_tuser
);

	// an offered byte stays put until it is taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
		else $error("input changed while stalled");

	// a result held under backpressure keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a valid rom always has a zero residue
	a_valid_crc: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 8'h00)
		else $error("rom_valid set with nonzero crc");

	// a fresh result follows a last-byte transfer, taken through the input and result registers
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
		else $error("result without a last byte");

endmodule

bind onewire_rom_crc_checker owcrc_checker u_owcrc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// File: dv/tb_top.sv
`timescale 1ns / 1ps

typedef logic [7:0] byte_q_t[$];

// tracks the message being sent and holds the roms the block still owes us
class rom_crc_tracker;
	logic [7:0] crc_acc;
	bit         only_zeros;
	bit         only_ones;
	logic [3:0] byte_count;
	owcrc_pkg::result_t pending_roms[$];
	int unsigned mismatches;

	function new();
		mismatches = 0;
		clear_message();
	endfunction

	function void clear_message();
		crc_acc    = owcrc_pkg::CRC_INIT;
		only_zeros = 1'b1;
		only_ones  = 1'b1;
		byte_count = '0;
	endfunction

	// reflected crc-8, one bit at a time, lsb first
	static function logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc;
		for (int k = 0; k < 8; k++) begin
			if (c[0] ^ data[k]) begin
				c = (c >> 1) ^ owcrc_pkg::CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	function void take_byte(input logic [7:0] data, input logic last);
		owcrc_pkg::result_t r;
		crc_acc = crc_step(crc_acc, data);
		if (data != owcrc_pkg::BYTE_ZERO) begin
			only_zeros = 1'b0;
		end
		if (data != owcrc_pkg::BYTE_ONES) begin
			only_ones = 1'b0;
		end
		if (byte_count < owcrc_pkg::COUNT_MAX) begin
			byte_count++;
		end
		if (last) begin
			r.crc_value = crc_acc;
			r.rom_valid = (byte_count == owcrc_pkg::ROM_COUNT) && !only_zeros && !only_ones
				&& (crc_acc == 8'd0);
			pending_roms.push_back(r);
			clear_message();
		end
	endfunction

	function void check_rom(input logic [7:0] crc, input logic valid);
		owcrc_pkg::result_t exp_rom;
		if (pending_roms.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("unexpected result: crc %h valid %b", crc, valid);
			end
		end else begin
			exp_rom = pending_roms.pop_front();
			if (exp_rom.crc_value !== crc || exp_rom.rom_valid !== valid) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: crc exp %h got %h, valid exp %b got %b",
						exp_rom.crc_value, crc, exp_rom.rom_valid, valid);
				end
			end
		end
	endfunction
endclass

module tb_top;
	import owcrc_pkg::*;

	localparam int unsigned ITEM_TARGET = 900;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES = 300;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic       m_tuser;

	rom_crc_tracker board = new();
	int unsigned sent_bytes = 0;
	int unsigned quiet_cycles = 0;

	always #2 clk = ~clk;

	onewire_rom_crc_checker u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	function automatic byte_q_t random_bytes(input int n);
		byte_q_t q;
		for (int i = 0; i < n; i++) begin
			q.push_back(8'($urandom));
		end
		return q;
	endfunction

	function automatic byte_q_t fill_bytes(input logic [7:0] v, input int n);
		byte_q_t q;
		for (int i = 0; i < n; i++) begin
			q.push_back(v);
		end
		return q;
	endfunction

	// random body followed by its own crc, so the crc over the whole message is zero
	function automatic byte_q_t build_rom(input int n);
		byte_q_t q;
		logic [7:0] c;
		q = random_bytes(n - 1);
		c = CRC_INIT;
		foreach (q[i]) begin
			c = board.crc_step(c, q[i]);
		end
		q.push_back(c);
		return q;
	endfunction

	task automatic send_byte(input logic [7:0] data, input logic last);
		bit quiet;
		quiet = sent_bytes >= 300 && sent_bytes < 500;
		while (!quiet && $urandom_range(0, 99) < 19) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		board.take_byte(data, last);
		sent_bytes++;
	endtask

	task automatic send_message(input byte_q_t msg);
		foreach (msg[i]) begin
			send_byte(msg[i], i == msg.size() - 1);
		end
	endtask

	// result side, with one long hold-off so that last bytes back up into the input
	initial begin
		int unsigned taken;
		int unsigned hold;
		bit held;
		taken = 0;
		hold = 0;
		held = 1'b0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				board.check_rom(m_tdata, m_tuser);
				taken++;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else if (taken == 25 && !held) begin
				held = 1'b1;
				hold = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (taken >= 40 && taken < 90) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= 19);
			end
		end
	end

	// no transfer on either side for too long means the block is stuck
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		byte_q_t msg;
		int kind;
		int idx;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tlast  <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-byte messages straight after reset
		send_message(fill_bytes(BYTE_ONES, 1));
		send_message(fill_bytes(BYTE_ZERO, 1));
		// well-formed rom, then all zeros (crc zero but not valid)
		send_message(build_rom(ROM_BYTES));
		send_message(fill_bytes(BYTE_ZERO, ROM_BYTES));
		// two-byte message ending on all ones
		send_message(fill_bytes(BYTE_ONES, 2));

		while (sent_bytes < ITEM_TARGET) begin
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				msg = build_rom(ROM_BYTES);
			end else if (kind < 65) begin
				msg = build_rom(ROM_BYTES);
				idx = $urandom_range(0, ROM_BYTES - 1);
				msg[idx] = msg[idx] ^ (8'h01 << $urandom_range(0, 7));
			end else if (kind < 73) begin
				msg = build_rom($urandom_range(0, 1) ? ROM_BYTES - 1 : ROM_BYTES + 1);
			end else if (kind < 79) begin
				msg = fill_bytes(BYTE_ZERO, $urandom_range(0, 1) ? ROM_BYTES
					: $urandom_range(1, 16));
			end else if (kind < 85) begin
				msg = fill_bytes(BYTE_ONES, $urandom_range(0, 1) ? ROM_BYTES
					: $urandom_range(1, 16));
			end else if (kind < 93) begin
				msg = random_bytes($urandom_range(1, 20));
			end else begin
				// lengths near and past the saturating count
				msg = build_rom($urandom_range(14, 24));
			end
			send_message(msg);
		end
		s_tvalid <= 1'b0;

		while (board.pending_roms.size() > 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (board.mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
